// File: src/kbec_pkg.sv
// Shared types, widths and constants of the knob and button event classifier.
`default_nettype none

package kbec_pkg;

  localparam int unsigned PosWidthDef  = 16;
  localparam int unsigned TimeWidth    = 32;
  localparam int unsigned WindowWidth  = 16;
  localparam int unsigned LimitWidth   = 16;
  localparam int unsigned ThrWidth     = 15;
  localparam int unsigned HeldWidth    = 16;
  localparam int unsigned EventWidth   = 3;
  localparam int unsigned CfgIdxWidth  = 2;
  localparam int unsigned CfgDataWidth = 16;

  localparam logic [WindowWidth-1:0] WindowRst = WindowWidth'(400);
  localparam logic [LimitWidth-1:0]  LimitRst  = LimitWidth'(1000);
  localparam logic [ThrWidth-1:0]    ThrRst    = ThrWidth'(4);

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_WINDOW    = 2'd0,
    CFG_LIMIT     = 2'd1,
    CFG_THRESHOLD = 2'd2
  } cfg_idx_e;

  typedef enum logic [EventWidth-1:0] {
    EV_NONE   = 3'd0,
    EV_CW     = 3'd1,
    EV_CCW    = 3'd2,
    EV_CLICK  = 3'd3,
    EV_DOUBLE = 3'd4,
    EV_LONG   = 3'd5
  } event_e;

  typedef struct packed {
    logic [WindowWidth-1:0] window;
    logic [LimitWidth-1:0]  limit;
    logic [ThrWidth-1:0]    threshold;
  } cfg_t;

endpackage

`default_nettype wire

// File: src/kbec_if.sv
// Valid/ready channel interfaces for poll requests and event results.
`default_nettype none

interface kbec_in_if import kbec_pkg::*; #(
  parameter int unsigned PosWidth = PosWidthDef
) ();
  logic                 valid;
  logic                 ready;
  logic [PosWidth-1:0]  encoder_count;
  logic                 button_level;
  logic [TimeWidth-1:0] current_time;

  modport source (output valid, encoder_count, button_level, current_time, input ready);
  modport sink   (input valid, encoder_count, button_level, current_time, output ready);
endinterface

interface kbec_out_if import kbec_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [EventWidth-1:0] event_code;

  modport source (output valid, event_code, input ready);
  modport sink   (input valid, event_code, output ready);
endinterface

`default_nettype wire

// File: src/kbec_cfg.sv
// Configuration registers: double-click window, long-press limit, step threshold.
`default_nettype none

module kbec_cfg import kbec_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [CfgDataWidth-1:0] cfg_data_i,
  output cfg_t                    cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window    <= WindowRst;
      cfg_q.limit     <= LimitRst;
      cfg_q.threshold <= ThrRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_WINDOW:    cfg_q.window    <= cfg_data_i[WindowWidth-1:0];
        CFG_LIMIT:     cfg_q.limit     <= cfg_data_i[LimitWidth-1:0];
        CFG_THRESHOLD: cfg_q.threshold <= cfg_data_i[ThrWidth-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: src/kbec_core.sv
// Classifier state and the single-pass decision logic for one poll.
`default_nettype none

module kbec_core import kbec_pkg::*; #(
  parameter int unsigned PosWidth = PosWidthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 take_i,
  input  logic [PosWidth-1:0]  pos_i,
  input  logic                 level_i,
  input  logic [TimeWidth-1:0] time_i,
  input  cfg_t                 cfg_i,
  output event_e               event_o
);

  localparam int unsigned CmpWidth = (PosWidth > ThrWidth) ? PosWidth : ThrWidth;

  logic [PosWidth-1:0]  last_pos_q;
  logic                 prev_level_q, prev_level_d;
  logic [HeldWidth-1:0] held_q, held_d;
  logic                 pending_q, pending_d;
  logic [TimeWidth-1:0] rel_time_q, rel_time_d;

  logic [PosWidth-1:0]  delta;
  logic [PosWidth-1:0]  mag;
  logic [TimeWidth-1:0] elapsed;
  logic [HeldWidth-1:0] held_inc;
  logic                 expired;
  logic                 rotate;
  event_e               rot_event;
  event_e               event_d;

  assign delta    = pos_i - last_pos_q;
  assign mag      = delta[PosWidth-1] ? (~delta + PosWidth'(1)) : delta;
  assign elapsed  = time_i - rel_time_q;
  assign expired  = elapsed >= TimeWidth'(cfg_i.window);
  assign held_inc = (held_q == {HeldWidth{1'b1}}) ? held_q : held_q + HeldWidth'(1);

  always_comb begin
    rot_event = EV_NONE;
    if (CmpWidth'(mag) >= CmpWidth'(cfg_i.threshold)) begin
      rot_event = delta[PosWidth-1] ? EV_CCW : EV_CW;
    end
  end

  always_comb begin
    event_d      = EV_NONE;
    prev_level_d = prev_level_q;
    held_d       = held_q;
    pending_d    = pending_q;
    rel_time_d   = rel_time_q;
    rotate       = 1'b0;
    if (pending_q && expired) begin
      // window ran out: the edge on this poll is seen on the next one
      pending_d = 1'b0;
      event_d   = EV_CLICK;
    end else if (!level_i && !prev_level_q && (held_inc > cfg_i.limit)) begin
      held_d    = '0;
      pending_d = 1'b0;
      event_d   = EV_LONG;
    end else if (!level_i && prev_level_q) begin
      held_d       = '0;
      prev_level_d = 1'b0;
    end else if (level_i && !prev_level_q) begin
      prev_level_d = 1'b1;
      held_d       = '0;
      if ((held_q != '0) && (held_q < cfg_i.limit)) begin
        if (pending_q) begin
          pending_d = 1'b0;
          event_d   = EV_DOUBLE;
        end else begin
          pending_d  = 1'b1;
          rel_time_d = time_i;
        end
      end else begin
        rotate = 1'b1;
      end
    end else begin
      if (!level_i) begin
        held_d = held_inc;
      end
      rotate = 1'b1;
    end
    if (rotate) begin
      event_d = rot_event;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_pos_q   <= '0;
      prev_level_q <= 1'b1;
      held_q       <= '0;
      pending_q    <= 1'b0;
      rel_time_q   <= '0;
    end else if (take_i) begin
      last_pos_q   <= pos_i;
      prev_level_q <= prev_level_d;
      held_q       <= held_d;
      pending_q    <= pending_d;
      rel_time_q   <= rel_time_d;
    end
  end

  assign event_o = event_d;

endmodule

`default_nettype wire

// File: src/knob_and_button_event_classifier_unit.sv
// Top level of the knob and button event classifier.
// Each poll request (encoder count, active-low button level, millisecond time)
// yields exactly one event: none, clockwise, counter-clockwise, click, double
// click or long press. A poll is registered on entry, classified by one pass of
// compare logic against the held state, and the event lands in an output
// register. One poll is accepted every cycle unless the output stalls, the
// rate being set by the single state update per poll in kbec_core. The input
// stays open while an event waits, as long as the output register can move.
// Configuration writes are expected only while no poll is in flight.
`default_nettype none

module knob_and_button_event_classifier_unit import kbec_pkg::*; #(
  parameter int unsigned POSITION_WIDTH = PosWidthDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [CfgDataWidth-1:0] cfg_data_i,
  kbec_in_if.sink                 in_if,
  kbec_out_if.source              out_if
);

  cfg_t                      cfg;
  logic                      in_valid_q;
  logic [POSITION_WIDTH-1:0] pos_q;
  logic                      level_q;
  logic [TimeWidth-1:0]      time_q;
  logic                      out_valid_q;
  event_e                    event_q;
  event_e                    event_d;
  logic                      advance;
  logic                      in_take;

  assign advance     = in_valid_q && (!out_valid_q || out_if.ready);
  assign in_if.ready = !in_valid_q || advance;
  assign in_take     = in_if.valid && in_if.ready;

  kbec_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  kbec_core #(
    .PosWidth (POSITION_WIDTH)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .take_i  (advance),
    .pos_i   (pos_q),
    .level_i (level_q),
    .time_i  (time_q),
    .cfg_i   (cfg),
    .event_o (event_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      pos_q   <= in_if.encoder_count;
      level_q <= in_if.button_level;
      time_q  <= in_if.current_time;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      event_q <= event_d;
    end
  end

  assign out_if.valid      = out_valid_q;
  assign out_if.event_code = event_q;

endmodule

`default_nettype wire
